// File: design/mfpf_pkg.sv
// ----------------------------------------------------------------------------
// mfpf_pkg
// Shared widths, types and sequencer states of the most frequent prime
// factor block.
// ----------------------------------------------------------------------------
package mfpf_pkg;

  localparam int VALUE_WIDTH = 31;
  localparam int FIELD_W     = 31;
  localparam int COUNT_W     = 5;
  localparam int STEP_W      = $clog2(VALUE_WIDTH);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [COUNT_W-1:0]     count_t;

  typedef struct packed {
    logic   start;
    value_t dividend;
    value_t divisor;
  } div_req_t;

  typedef struct packed {
    logic   done;
    value_t quotient;
    value_t remainder;
  } div_rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_FINAL
  } state_t;

endpackage

// File: design/mfpf_in_if.sv
// ----------------------------------------------------------------------------
// mfpf_in_if
// Input channel: one number to factor per transfer.
// ----------------------------------------------------------------------------
interface mfpf_in_if;

  logic                        valid;
  logic                        ready;
  logic [mfpf_pkg::FIELD_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);

endinterface

// File: design/mfpf_out_if.sv
// ----------------------------------------------------------------------------
// mfpf_out_if
// Result channel: most frequent prime factor and its multiplicity.
// ----------------------------------------------------------------------------
interface mfpf_out_if;

  logic                         valid;
  logic                         ready;
  logic [mfpf_pkg::FIELD_W-1:0] best_factor;
  logic [mfpf_pkg::COUNT_W-1:0] multiplicity;

  modport source (output valid, output best_factor, output multiplicity, input ready);
  modport sink   (input valid, input best_factor, input multiplicity, output ready);

endinterface

// File: design/mfpf_divider.sv
// ----------------------------------------------------------------------------
// mfpf_divider
// Restoring divider, one quotient bit per cycle, VALUE_WIDTH quotient bits per
// division. The divisor is never zero in this block.
// ----------------------------------------------------------------------------
module mfpf_divider (
  input  logic               clk,
  input  logic               rst,
  input  mfpf_pkg::div_req_t req,
  output mfpf_pkg::div_rsp_t rsp
);

  localparam logic [mfpf_pkg::STEP_W-1:0] LAST_STEP =
    mfpf_pkg::STEP_W'(mfpf_pkg::VALUE_WIDTH - 1);

  logic                              busy;
  logic                              done;
  logic [mfpf_pkg::STEP_W-1:0]       step;
  logic [mfpf_pkg::VALUE_WIDTH:0]    rem;
  mfpf_pkg::value_t                  quo;
  mfpf_pkg::value_t                  divisor;
  logic [mfpf_pkg::VALUE_WIDTH:0]    rem_shift;
  logic [mfpf_pkg::VALUE_WIDTH:0]    rem_diff;
  logic                              fits;

  always_comb begin
    rem_shift = {rem[mfpf_pkg::VALUE_WIDTH-1:0], quo[mfpf_pkg::VALUE_WIDTH-1]};
    rem_diff  = rem_shift - {1'b0, divisor};
    fits      = rem_shift >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? rem_diff : rem_shift;
      quo <= {quo[mfpf_pkg::VALUE_WIDTH-2:0], fits};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem[mfpf_pkg::VALUE_WIDTH-1:0];

endmodule

// File: design/most_frequent_prime_factor.sv
// ----------------------------------------------------------------------------
// most_frequent_prime_factor
// Trial-division factorization that returns the prime factor of highest
// multiplicity (smallest on a tie) and its count.
//
// Usage:
//   request carries one number per transfer; result returns one item
//   (best_factor, multiplicity) per number. A number below two gives 0, 0.
//   request.ready is high only while the sequencer is idle, so one number is
//   factored at a time.
// Trial steps:
//   Every trial step is one division of the remaining value by the current
//   divisor on the shared restoring divider. A number takes D + F trial steps,
//   with D the divisors tried (up to 46340 for a prime near 2^31) and F the
//   prime factors removed; inputs below two take no trial step.
// Reset:
//   rst clears the sequencer and the result valid; no storage needs clearing.
// Stall:
//   The result sits in an output register until taken. The next number is
//   accepted meanwhile; its result waits in the final step for the register.
// ----------------------------------------------------------------------------
module most_frequent_prime_factor (
  input  logic        clk,
  input  logic        rst,
  mfpf_in_if.sink     request,
  mfpf_out_if.source  result
);

  mfpf_pkg::state_t   state;
  mfpf_pkg::state_t   state_next;
  mfpf_pkg::value_t   rest;
  mfpf_pkg::value_t   divisor;
  mfpf_pkg::value_t   best;
  mfpf_pkg::count_t   count;
  mfpf_pkg::count_t   best_count;
  logic               first;
  logic               out_valid;
  mfpf_pkg::div_req_t div_req;
  mfpf_pkg::div_rsp_t div_rsp;
  logic               exit_loop;
  logic               divides;

  mfpf_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign exit_loop = first && (divisor > div_rsp.quotient);
  assign divides   = div_rsp.remainder == '0;

  always_comb begin
    state_next = state;
    case (state)
      mfpf_pkg::S_IDLE: begin
        if (request.valid) begin
          if (mfpf_pkg::VALUE_WIDTH'(request.number) >= mfpf_pkg::VALUE_WIDTH'(2)) begin
            state_next = mfpf_pkg::S_START;
          end else begin
            state_next = mfpf_pkg::S_FINAL;
          end
        end
      end
      mfpf_pkg::S_START: state_next = mfpf_pkg::S_WAIT;
      mfpf_pkg::S_WAIT: begin
        if (div_rsp.done) begin
          state_next = exit_loop ? mfpf_pkg::S_FINAL : mfpf_pkg::S_START;
        end
      end
      mfpf_pkg::S_FINAL: begin
        if (!out_valid) begin
          state_next = mfpf_pkg::S_IDLE;
        end
      end
      default: state_next = mfpf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    request.ready    = state == mfpf_pkg::S_IDLE;
    div_req.start    = state == mfpf_pkg::S_START;
    div_req.dividend = rest;
    div_req.divisor  = divisor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfpf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mfpf_pkg::S_IDLE && request.valid) begin
      rest       <= mfpf_pkg::VALUE_WIDTH'(request.number);
      divisor    <= mfpf_pkg::VALUE_WIDTH'(2);
      best       <= '0;
      count      <= '0;
      best_count <= '0;
      first      <= 1'b1;
    end else if (state == mfpf_pkg::S_WAIT && div_rsp.done && !exit_loop) begin
      if (divides) begin
        rest  <= div_rsp.quotient;
        count <= count + 1'b1;
        first <= 1'b0;
      end else begin
        if (count > best_count) begin
          best       <= divisor;
          best_count <= count;
        end
        divisor <= divisor + 1'b1;
        count   <= '0;
        first   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == mfpf_pkg::S_FINAL && !out_valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mfpf_pkg::S_FINAL && !out_valid) begin
      if (rest > mfpf_pkg::VALUE_WIDTH'(1) && best_count == '0) begin
        result.best_factor  <= mfpf_pkg::FIELD_W'(rest);
        result.multiplicity <= mfpf_pkg::COUNT_W'(1);
      end else begin
        result.best_factor  <= mfpf_pkg::FIELD_W'(best);
        result.multiplicity <= best_count;
      end
    end
  end

  assign result.valid = out_valid;

endmodule
